/* rtl/c_escape_sequence_decoder_top_macros.svh */
// ---------------------------------------------------------------------------
// C escape sequence decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH
`define C_ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH

// Property that must hold at every edge outside reset.
`define CESD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CESD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cesd_pkg.sv */
// ---------------------------------------------------------------------------
// C escape sequence decoder: package
// Decoder modes, result records and character helpers.
// ---------------------------------------------------------------------------
package cesd_pkg;

	typedef enum logic [4:0] {
		MODE_TEXT = 5'b00001,
		MODE_ESC  = 5'b00010,
		MODE_OCT  = 5'b00100,
		MODE_HEX  = 5'b01000,
		MODE_SKIP = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       error;
		logic       last;
	} result_t;

	// Up to two results produced by one input byte
	typedef struct packed {
		result_t    res0;
		result_t    res1;
		logic [1:0] cnt;
	} push_t;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_X    = 8'h78;
	localparam logic [1:0] OCT_LAST  = 2'd2;  // digits held when the third arrives
	localparam logic [1:0] HEX_LAST  = 2'd1;  // digits held when the second arrives

	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;
	localparam int RQ_CW    = 3;

	function automatic logic [7:0] named_escape(input logic [7:0] b);
		logic [7:0] r;
		case (b)
			8'h61:   r = 8'd7;   // a
			8'h62:   r = 8'd8;   // b
			8'h66:   r = 8'd12;  // f
			8'h6E:   r = 8'd10;  // n
			8'h72:   r = 8'd13;  // r
			8'h74:   r = 8'd9;   // t
			8'h76:   r = 8'd11;  // v
			default: r = b;
		endcase
		return r;
	endfunction

	function automatic logic is_oct_digit(input logic [7:0] b);
		return b[7:3] == 5'b00110;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		if (b >= 8'h30 && b <= 8'h39)
			r = {1'b1, b[3:0]};
		else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		else
			r = 5'd0;
		return r;
	endfunction

endpackage

/* rtl/cesd_decode.sv */
// ---------------------------------------------------------------------------
// C escape sequence decoder: decode stage
// Input register, escape state and single-pass decode into up to two results.
// ---------------------------------------------------------------------------
module cesd_decode import cesd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       room,
	output push_t      push
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	mode_t      mode_q, mode_d;
	logic [8:0] ev_q, ev_d;
	logic [1:0] dc_q, dc_d;
	logic       fire;
	logic       advance;
	logic       oct;
	logic [4:0] hex;
	logic [8:0] oct_v, hex_v;
	push_t      push_c;

	assign fire    = valid_s1 && room;
	assign advance = !valid_s1 || room;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
			ev_q   <= '0;
			dc_q   <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			ev_q   <= ev_d;
			dc_q   <= dc_d;
		end
	end

	assign oct   = is_oct_digit(byte_s1);
	assign hex   = hex_digit(byte_s1);
	assign oct_v = {ev_q[5:0], byte_s1[2:0]};
	assign hex_v = {ev_q[4:0], hex[3:0]};

	always_comb begin
		mode_d = mode_q;
		ev_d   = ev_q;
		dc_d   = dc_q;
		push_c = '0;
		unique case (mode_q)
			MODE_ESC: begin
				ev_d = '0;
				dc_d = '0;
				if (oct) begin
					ev_d   = {6'd0, byte_s1[2:0]};
					dc_d   = 2'd1;
					mode_d = MODE_OCT;
				end else if (byte_s1 == CHAR_X) begin
					mode_d = MODE_HEX;
				end else begin
					mode_d      = MODE_TEXT;
					push_c.res0 = '{named_escape(byte_s1), 1'b0, byte_s1 == 8'd0};
					push_c.cnt  = 2'd1;
				end
			end
			MODE_OCT, MODE_HEX: begin
				if ((mode_q == MODE_OCT) ? oct : hex[4]) begin
					if (dc_q >= ((mode_q == MODE_OCT) ? OCT_LAST : HEX_LAST)) begin
						ev_d       = '0;
						dc_d       = '0;
						push_c.cnt = 2'd1;
						if (mode_q == MODE_OCT && oct_v[8]) begin
							mode_d      = MODE_SKIP;
							push_c.res0 = '{8'd0, 1'b1, 1'b1};
						end else begin
							mode_d      = MODE_TEXT;
							push_c.res0 = '{(mode_q == MODE_OCT) ? oct_v[7:0] : hex_v[7:0],
								1'b0, 1'b0};
						end
					end else begin
						ev_d = (mode_q == MODE_OCT) ? oct_v : hex_v;
						dc_d = 2'(dc_q + 2'd1);
					end
				end else begin
					// Terminating byte: flush the value, then treat the byte as text
					ev_d        = '0;
					dc_d        = '0;
					push_c.res0 = '{ev_q[7:0], 1'b0, 1'b0};
					if (byte_s1 == BACKSLASH) begin
						mode_d     = MODE_ESC;
						push_c.cnt = 2'd1;
					end else begin
						mode_d      = MODE_TEXT;
						push_c.res1 = '{byte_s1, 1'b0, byte_s1 == 8'd0};
						push_c.cnt  = 2'd2;
					end
				end
			end
			MODE_SKIP: begin
				if (byte_s1 == 8'd0) begin
					mode_d = MODE_TEXT;
				end
			end
			default: begin
				ev_d = '0;
				dc_d = '0;
				if (byte_s1 == BACKSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					mode_d      = MODE_TEXT;
					push_c.res0 = '{byte_s1, 1'b0, byte_s1 == 8'd0};
					push_c.cnt  = 2'd1;
				end
			end
		endcase
		if (!fire) begin
			push_c.cnt = 2'd0;
		end
	end

	assign push = push_c;

endmodule

/* rtl/cesd_rq.sv */
// ---------------------------------------------------------------------------
// C escape sequence decoder: result queue
// Four-entry queue taking up to two results a cycle and giving one per transfer.
// ---------------------------------------------------------------------------
`include "c_escape_sequence_decoder_top_macros.svh"

module cesd_rq import cesd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  push_t      push,
	output logic       room,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       error,
	output logic       last
);

	result_t          mem [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q;
	logic [RQ_AW-1:0] rd_ptr_q;
	logic [RQ_CW-1:0] count_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && !out_stall;
	// Leave space for a two-result byte
	assign room      = count_q <= RQ_CW'(RQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_ptr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			mem[RQ_AW'(wr_ptr_q + 1'b1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= RQ_AW'(wr_ptr_q + RQ_AW'(push.cnt));
			rd_ptr_q <= RQ_AW'(rd_ptr_q + RQ_AW'(pop));
			count_q  <= RQ_CW'(count_q + RQ_CW'(push.cnt) - RQ_CW'(pop));
		end
	end

	assign out_byte = mem[rd_ptr_q].data;
	assign error    = mem[rd_ptr_q].error;
	assign last     = mem[rd_ptr_q].last;

	`CESD_ASSERT(a_rq_push_room, !(push.cnt != 2'd0 && !room), "rq: push without room")
	`CESD_ASSERT_NEXT(a_rq_count, 1'b1, count_q == RQ_CW'($past(count_q) + $past(RQ_CW'(push.cnt)) - $past(RQ_CW'(pop))), "rq: count lost track")
	`CESD_ASSERT(a_rq_err_last, !(push.cnt != 2'd0 && push.res0.error && !(push.res0.last && push.res0.data == 8'd0)), "rq: error result malformed")

endmodule

/* rtl/c_escape_sequence_decoder_top.sv */
// ---------------------------------------------------------------------------
// C escape sequence decoder: top level
// Decodes C backslash escapes in a zero-terminated byte stream.
// ---------------------------------------------------------------------------
// One raw byte is taken per transfer on the input and one decoded byte leaves
// per transfer on the output. Each accepted byte is decoded combinationally
// from its input register and yields zero, one or two results into a
// four-entry result queue; bytes are accepted every cycle while the queue has
// room for two results, so throughput is one byte per cycle and output-bound
// at one result per cycle while out_stall is low. The first result of a byte
// passes through the input register and is written into the queue before it
// becomes valid on the output. The terminating zero leaves with last set; an
// octal escape above 255 gives one result with error and last set, and the
// rest of that string, through its zero byte, is dropped.
module c_escape_sequence_decoder_top import cesd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       error,
	output logic       last
);

	push_t push;
	logic  room;

	cesd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.room     (room),
		.push     (push)
	);

	cesd_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.error     (error),
		.last      (last)
	);

endmodule
